// ===== src/dcf_pkg.sv =====
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and codes of the directed cycle finder: commands, node
// colours, sequencer states and the result word.
// ----------------------------------------------------------------------------
package dcf_pkg;

	// Field widths of the stream words
	localparam int unsigned CMD_W  = 2;
	localparam int unsigned NODE_W = 7;

	// Input commands
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// Node marking during the search
	typedef enum logic [1:0] {
		COL_WHITE = 2'd0,
		COL_GRAY  = 2'd1,
		COL_BLACK = 2'd2,
		COL_SPARE = 2'd3
	} colour_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_ROOT,
		ST_ROOT_CHK,
		ST_ROW,
		ST_SCAN,
		ST_NBR,
		ST_POP,
		ST_EMIT,
		ST_EMIT_OUT,
		ST_NONE
	} state_t;

	// One result word
	typedef struct packed {
		logic              found;
		logic [NODE_W-1:0] node;
		logic              last;
	} res_t;

endpackage

// ===== src/dcf_ram.sv =====
// ----------------------------------------------------------------------------
// dcf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when a read is issued.
// ----------------------------------------------------------------------------
module dcf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/dcf_out.sv =====
// ----------------------------------------------------------------------------
// dcf_out
// Output register of the result stream: holds one result word until the
// downstream side takes it.
// ----------------------------------------------------------------------------
module dcf_out (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  dcf_pkg::res_t res,
	output logic         free,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // [6:0] cycle_node, [7] zero
	output logic [0:0]   m_tuser,   // [0] found
	output logic         m_tlast    // last
);

	import dcf_pkg::*;

	logic valid_q;
	res_t res_q;

	assign free = !valid_q || m_tready;

	// Hold the valid flag; load on push, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign m_tvalid   = valid_q;
	assign m_tdata    = {1'b0, res_q.node};
	assign m_tuser[0] = res_q.found;
	assign m_tlast    = res_q.last;

endmodule

// ===== src/dcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcf_ctrl
// Search sequencer: loads edges into the adjacency memory, runs the
// depth-first search over the colour and stack memories, and pushes the
// cycle path or a not-found word to the output register.
// ----------------------------------------------------------------------------
module dcf_ctrl #(
	parameter int unsigned MAX_NODES = 64,
	parameter int unsigned IW        = $clog2(MAX_NODES),
	parameter int unsigned CW        = $clog2(MAX_NODES + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dcf_pkg::NODE_W-1:0]   cfg_data,
	// input word
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dcf_pkg::CMD_W-1:0]    cmd,
	input  logic [dcf_pkg::NODE_W-1:0]   src_node,
	input  logic [dcf_pkg::NODE_W-1:0]   dst_node,
	// adjacency memory
	output logic                         adj_we,
	output logic [IW-1:0]                adj_waddr,
	output logic [MAX_NODES-1:0]         adj_wdata,
	output logic                         adj_re,
	output logic [IW-1:0]                adj_raddr,
	input  logic [MAX_NODES-1:0]         adj_rdata,
	// colour memory: {colour, stack position}
	output logic                         col_we,
	output logic [IW-1:0]                col_waddr,
	output logic [IW+1:0]                col_wdata,
	output logic                         col_re,
	output logic [IW-1:0]                col_raddr,
	input  logic [IW+1:0]                col_rdata,
	// stack memory: {node, cursor}
	output logic                         stk_we,
	output logic [IW-1:0]                stk_waddr,
	output logic [IW+CW-1:0]             stk_wdata,
	output logic                         stk_re,
	output logic [IW-1:0]                stk_raddr,
	input  logic [IW+CW-1:0]             stk_rdata,
	// result stage
	input  logic                         out_free,
	output logic                         res_push,
	output dcf_pkg::res_t                res
);

	import dcf_pkg::*;

	state_t                state_q, state_d;
	logic [NODE_W-1:0]     node_count_q;
	logic [CW-1:0]         n_q, root_q, cur_q, depth_q;
	logic [IW-1:0]         u_q, c_q, e_q, s_q, d_q;
	logic [MAX_NODES-1:0]  row_q, row_valid_q, col_valid_q;
	logic                  rv_s1, cv_s1;

	logic                  take, in_range, nbr_white, nbr_gray, root_white;
	logic                  scan_done, scan_hit, emit_top, last_pop;
	logic [NODE_W-1:0]     src_m1, dst_m1;
	logic [CW-1:0]         n_lim, cur_inc, depth_m2;
	logic [IW-1:0]         top_pos;
	colour_t               col_rd;
	logic [IW-1:0]         pos_rd;

	// Decode the current word and memory read data
	assign take      = in_valid && in_ready;
	assign src_m1    = src_node - NODE_W'(1);
	assign dst_m1    = dst_node - NODE_W'(1);
	assign in_range  = (src_node != '0) && (src_node <= NODE_W'(MAX_NODES)) &&
	                   (dst_node != '0) && (dst_node <= NODE_W'(MAX_NODES));
	assign n_lim     = (node_count_q > NODE_W'(MAX_NODES)) ? CW'(MAX_NODES)
	                                                      : node_count_q[CW-1:0];
	assign col_rd    = cv_s1 ? colour_t'(col_rdata[IW+1:IW]) : COL_WHITE;
	assign pos_rd    = col_rdata[IW-1:0];
	assign nbr_white = (col_rd == COL_WHITE);
	assign nbr_gray  = (col_rd == COL_GRAY);
	assign root_white = (col_rd == COL_WHITE);
	assign scan_done = (cur_q >= n_q);
	assign scan_hit  = row_q[cur_q[IW-1:0]];
	assign cur_inc   = cur_q + CW'(1);
	assign depth_m2  = depth_q - CW'(2);
	assign top_pos   = IW'(depth_q - CW'(1));
	assign emit_top  = (e_q == top_pos);
	assign last_pop  = (depth_q == CW'(1));
	assign cfg_ready = 1'b1;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (cmd_t'(cmd))
						CMD_ADD: state_d = in_range ? ST_ADD_WR : ST_IDLE;
						CMD_RUN: state_d = ST_ROOT;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_WR:   state_d = ST_IDLE;
			ST_ROOT:     state_d = (root_q >= n_q) ? ST_NONE : ST_ROOT_CHK;
			ST_ROOT_CHK: state_d = root_white ? ST_ROW : ST_ROOT;
			ST_ROW:      state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_done) begin
					state_d = last_pop ? ST_ROOT : ST_POP;
				end else if (scan_hit) begin
					state_d = ST_NBR;
				end
			end
			ST_NBR: begin
				if (nbr_white && depth_q < CW'(MAX_NODES)) begin
					state_d = ST_ROW;
				end else if (nbr_gray) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_POP: state_d = ST_ROW;
			ST_EMIT: begin
				if (!emit_top) begin
					state_d = ST_EMIT_OUT;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_OUT: state_d = out_free ? ST_EMIT : ST_EMIT_OUT;
			ST_NONE:     state_d = out_free ? ST_IDLE : ST_NONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Memory controls and result pushes
	always_comb begin
		in_ready  = 1'b0;
		adj_we    = 1'b0;
		adj_waddr = s_q;
		adj_wdata = (rv_s1 ? adj_rdata : '0) | (MAX_NODES'(1) << d_q);
		adj_re    = 1'b0;
		adj_raddr = src_m1[IW-1:0];
		col_we    = 1'b0;
		col_waddr = u_q;
		col_wdata = {COL_BLACK, {IW{1'b0}}};
		col_re    = 1'b0;
		col_raddr = root_q[IW-1:0];
		stk_we    = 1'b0;
		stk_waddr = top_pos;
		stk_wdata = {u_q, cur_q};
		stk_re    = 1'b0;
		stk_raddr = e_q;
		res_push  = 1'b0;
		res       = '{found: 1'b1, node: NODE_W'(u_q) + NODE_W'(1), last: 1'b1};
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				adj_re   = take && (cmd_t'(cmd) == CMD_ADD) && in_range;
			end
			ST_ADD_WR: adj_we = 1'b1;
			ST_ROOT:   col_re = (root_q < n_q);
			ST_ROOT_CHK: begin
				if (root_white) begin
					col_we    = 1'b1;
					col_waddr = root_q[IW-1:0];
					col_wdata = {COL_GRAY, {IW{1'b0}}};
					adj_re    = 1'b1;
					adj_raddr = root_q[IW-1:0];
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					col_we    = 1'b1;
					stk_re    = !last_pop;
					stk_raddr = depth_m2[IW-1:0];
				end else if (scan_hit) begin
					col_re    = 1'b1;
					col_raddr = cur_q[IW-1:0];
				end
			end
			ST_NBR: begin
				if (nbr_white && depth_q < CW'(MAX_NODES)) begin
					stk_we    = 1'b1;
					col_we    = 1'b1;
					col_waddr = c_q;
					col_wdata = {COL_GRAY, depth_q[IW-1:0]};
					adj_re    = 1'b1;
					adj_raddr = c_q;
				end
			end
			ST_POP: begin
				adj_re    = 1'b1;
				adj_raddr = stk_rdata[IW+CW-1:CW];
			end
			ST_EMIT: begin
				if (!emit_top) begin
					stk_re = 1'b1;
				end else begin
					res_push = out_free;
				end
			end
			ST_EMIT_OUT: begin
				res_push = out_free;
				res = '{found: 1'b1,
				        node: NODE_W'(stk_rdata[IW+CW-1:CW]) + NODE_W'(1),
				        last: 1'b0};
			end
			ST_NONE: begin
				res_push = out_free;
				res      = '{found: 1'b0, node: '0, last: 1'b1};
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Control state, node count and per-entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= NODE_W'(64);
			row_valid_q  <= '0;
			col_valid_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (take && (cmd_t'(cmd) == CMD_CLEAR)) begin
				row_valid_q <= '0;
			end else if (adj_we) begin
				row_valid_q[adj_waddr] <= 1'b1;
			end
			if (take && (cmd_t'(cmd) == CMD_CLEAR || cmd_t'(cmd) == CMD_RUN)) begin
				col_valid_q <= '0;
			end else if (col_we) begin
				col_valid_q[col_waddr] <= 1'b1;
			end
		end
	end

	// Search registers
	always_ff @(posedge clk) begin
		if (adj_re) begin
			rv_s1 <= row_valid_q[adj_raddr];
		end
		if (col_re) begin
			cv_s1 <= col_valid_q[col_raddr];
		end
		case (state_q)
			ST_IDLE: begin
				s_q    <= src_m1[IW-1:0];
				d_q    <= dst_m1[IW-1:0];
				n_q    <= n_lim;
				root_q <= '0;
			end
			ST_ROOT_CHK: begin
				if (root_white) begin
					u_q     <= root_q[IW-1:0];
					cur_q   <= '0;
					depth_q <= CW'(1);
				end else begin
					root_q <= root_q + CW'(1);
				end
			end
			ST_ROW: row_q <= rv_s1 ? adj_rdata : '0;
			ST_SCAN: begin
				if (scan_done) begin
					depth_q <= depth_q - CW'(1);
					if (last_pop) begin
						root_q <= root_q + CW'(1);
					end
				end else begin
					cur_q <= cur_inc;
					c_q   <= cur_q[IW-1:0];
				end
			end
			ST_NBR: begin
				if (nbr_white && depth_q < CW'(MAX_NODES)) begin
					u_q     <= c_q;
					cur_q   <= '0;
					depth_q <= depth_q + CW'(1);
				end else if (nbr_gray) begin
					e_q <= pos_rd;
				end
			end
			ST_POP: begin
				u_q   <= stk_rdata[IW+CW-1:CW];
				cur_q <= stk_rdata[CW-1:0];
			end
			ST_EMIT_OUT: begin
				if (out_free) begin
					e_q <= e_q + IW'(1);
				end
			end
			default: begin
				e_q <= e_q;
			end
		endcase
	end

endmodule

// ===== src/directed_cycle_finder_core.sv =====
// ----------------------------------------------------------------------------
// directed_cycle_finder_core
// Directed graph cycle finder: adjacency bit matrix loaded edge by edge and a
// depth-first search that reports the first cycle found.
// ----------------------------------------------------------------------------
// Input words are taken only while the sequencer is idle. An add-edge word
// does a read-modify-write of one adjacency row, a clear or unknown word is
// handled in the idle state; clear and reset empty the graph at once through
// per-row valid bits, so there is no clearing pass. A run word occupies the
// block until its last result is loaded into the output register: a colour
// memory read per root tried; per node visited a row load, then one adjacency
// bit tested per cycle over n = min(node_count, MAX_NODES) positions, paused
// for a colour memory read at each set bit met, then a finishing step; per
// return to a parent a stack memory read and a row reload; then the cycle
// nodes are reported from the gray node to the top of the path, or the
// not-found word, each waiting while the output register is full. All state
// sits in single-port-read memories with a registered read. Results leave
// through one output register, so a new word may be accepted while the last
// result of a run still waits downstream.
// ----------------------------------------------------------------------------
module directed_cycle_finder_core #(
	parameter int unsigned MAX_NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: node_count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [6:0] src_node, [13:7] dst_node, [15:14] zero
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] cycle_node, [7] zero
	output logic [0:0]  m_tuser,   // [0] found
	output logic        m_tlast
);

	import dcf_pkg::*;

	localparam int unsigned IW = $clog2(MAX_NODES);
	localparam int unsigned CW = $clog2(MAX_NODES + 1);

	logic                 adj_we, adj_re, col_we, col_re, stk_we, stk_re;
	logic [IW-1:0]        adj_waddr, adj_raddr, col_waddr, col_raddr;
	logic [IW-1:0]        stk_waddr, stk_raddr;
	logic [MAX_NODES-1:0] adj_wdata, adj_rdata;
	logic [IW+1:0]        col_wdata, col_rdata;
	logic [IW+CW-1:0]     stk_wdata, stk_rdata;
	logic                 out_free, res_push;
	res_t                 res;

	// Search sequencer
	dcf_ctrl #(
		.MAX_NODES (MAX_NODES),
		.IW        (IW),
		.CW        (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cmd       (s_tuser),
		.src_node  (s_tdata[6:0]),
		.dst_node  (s_tdata[13:7]),
		.adj_we    (adj_we),
		.adj_waddr (adj_waddr),
		.adj_wdata (adj_wdata),
		.adj_re    (adj_re),
		.adj_raddr (adj_raddr),
		.adj_rdata (adj_rdata),
		.col_we    (col_we),
		.col_waddr (col_waddr),
		.col_wdata (col_wdata),
		.col_re    (col_re),
		.col_raddr (col_raddr),
		.col_rdata (col_rdata),
		.stk_we    (stk_we),
		.stk_waddr (stk_waddr),
		.stk_wdata (stk_wdata),
		.stk_re    (stk_re),
		.stk_raddr (stk_raddr),
		.stk_rdata (stk_rdata),
		.out_free  (out_free),
		.res_push  (res_push),
		.res       (res)
	);

	// Adjacency rows, one bit per destination
	dcf_ram #(
		.WIDTH (MAX_NODES),
		.DEPTH (MAX_NODES)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.re    (adj_re),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	// Node colour with stack position of gray nodes
	dcf_ram #(
		.WIDTH (IW + 2),
		.DEPTH (MAX_NODES)
	) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_waddr),
		.wdata (col_wdata),
		.re    (col_re),
		.raddr (col_raddr),
		.rdata (col_rdata)
	);

	// Path stack below the top entry: node and neighbor cursor
	dcf_ram #(
		.WIDTH (IW + CW),
		.DEPTH (MAX_NODES)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Result output register
	dcf_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== dv/directed_cycle_finder_core_tb.sv =====
// ----------------------------------------------------------------------------
// directed_cycle_finder_core_tb
// Self-checking bench for the directed cycle finder. A short table of words
// covers the corner cases (out-of-range edges, self loops, node count 0, 1 and
// above the node limit, clear, the unused command). Random phases follow:
// each phase sets a node count, loads edges and runs the search. One phase is
// a ring through all 64 nodes. Typed table rows give their result word, a
// behavioral search the rest, and each word out is checked field by field.
// ----------------------------------------------------------------------------
module directed_cycle_finder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dcf_pkg::*;

	localparam int unsigned GRAPH_NODES   = 64;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned LONG_HOLD     = 600;
	localparam int unsigned STALL_LIMIT   = 40000;
	localparam int unsigned TARGET_WORDS  = 350;
	localparam int unsigned OPENING_ROWS  = 25;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [6:0] src_node, [13:7] dst_node, [15:14] zero
	logic [1:0]  s_tuser;   // [1:0] cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [6:0] cycle_node, [7] zero
	logic [0:0]  m_tuser;   // [0] found
	logic        m_tlast;

	directed_cycle_finder_core #(
		.MAX_NODES(GRAPH_NODES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Bench copy of the graph and the node count register
	logic [63:0] edge_rows [GRAPH_NODES] = '{default: '0};
	logic [6:0]  node_count_q = 7'd64;
	res_t        pending_cycle_words [$];
	int unsigned graph_words = 0;
	int unsigned error_count = 0;
	int unsigned feed_gap_max = 19;
	bit          hold_armed = 1'b0;

	localparam res_t NO_CYCLE = '{1'b0, 7'd0, 1'b1};

	typedef struct {
		cmd_t       cmd;
		logic [6:0] src;
		logic [6:0] dst;
		bit         set_cfg;
		logic [6:0] cfg;
		bit         typed;
		res_t       res;
	} opening_row_t;

	// Directed words; typed rows carry their single result word
	opening_row_t opening_words [OPENING_ROWS] = '{
		'{CMD_RUN,   7'd0,   7'd0,   1'b0, 7'd0,   1'b1, NO_CYCLE},
		'{CMD_ADD,   7'd0,   7'd5,   1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_ADD,   7'd127, 7'd127, 1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_ADD,   7'd5,   7'd0,   1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_ADD,   7'd65,  7'd1,   1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_RUN,   7'd0,   7'd0,   1'b0, 7'd0,   1'b1, NO_CYCLE},
		'{CMD_NOP,   7'd64,  7'd64,  1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_RUN,   7'd0,   7'd0,   1'b0, 7'd0,   1'b1, NO_CYCLE},
		'{CMD_ADD,   7'd64,  7'd64,  1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_RUN,   7'd0,   7'd0,   1'b0, 7'd0,   1'b1, '{1'b1, 7'd64, 1'b1}},
		'{CMD_CLEAR, 7'd0,   7'd0,   1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_RUN,   7'd0,   7'd0,   1'b0, 7'd0,   1'b1, NO_CYCLE},
		'{CMD_ADD,   7'd1,   7'd2,   1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_ADD,   7'd2,   7'd3,   1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_ADD,   7'd3,   7'd1,   1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_RUN,   7'd0,   7'd0,   1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_ADD,   7'd1,   7'd1,   1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_RUN,   7'd0,   7'd0,   1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_RUN,   7'd0,   7'd0,   1'b1, 7'd0,   1'b1, NO_CYCLE},
		'{CMD_RUN,   7'd0,   7'd0,   1'b1, 7'd1,   1'b1, '{1'b1, 7'd1, 1'b1}},
		'{CMD_ADD,   7'd2,   7'd1,   1'b1, 7'd2,   1'b0, NO_CYCLE},
		'{CMD_RUN,   7'd0,   7'd0,   1'b0, 7'd0,   1'b0, NO_CYCLE},
		'{CMD_RUN,   7'd127, 7'd127, 1'b1, 7'd127, 1'b0, NO_CYCLE},
		'{CMD_CLEAR, 7'd0,   7'd0,   1'b1, 7'd100, 1'b0, NO_CYCLE},
		'{CMD_RUN,   7'd0,   7'd0,   1'b0, 7'd0,   1'b1, NO_CYCLE}
	};

	// Depth-first search with three-colour marking; queue the cycle path or a
	// single not-found word
	function automatic void search_for_cycle();
		colour_t shade [GRAPH_NODES];
		int      stack_at [GRAPH_NODES];
		int      cursor [GRAPH_NODES];
		int      span, root, depth, top, u, c, x;
		bit      hit;
		span = (node_count_q > GRAPH_NODES) ? GRAPH_NODES : int'(node_count_q);
		foreach (shade[i]) shade[i] = COL_WHITE;
		hit = 1'b0;
		depth = 0;
		for (root = 0; root < span && !hit; root++) begin
			if (shade[root] != COL_WHITE)
				continue;
			stack_at[0] = root;
			cursor[0] = 0;
			shade[root] = COL_GRAY;
			depth = 1;
			while (depth > 0 && !hit) begin
				top = depth - 1;
				u = stack_at[top];
				c = cursor[top];
				if (c >= span) begin
					// all neighbours tried: finish node and pop
					shade[u] = COL_BLACK;
					depth--;
				end else begin
					cursor[top] = c + 1;
					if (edge_rows[u][c]) begin
						if (shade[c] == COL_WHITE) begin
							if (depth < GRAPH_NODES) begin
								stack_at[depth] = c;
								cursor[depth] = 0;
								shade[c] = COL_GRAY;
								depth++;
							end
						end else if (shade[c] == COL_GRAY) begin
							// back edge: emit stack from c up to the top
							x = 0;
							while (x <= top && stack_at[x] != c)
								x++;
							while (x <= top) begin
								pending_cycle_words.push_back(
									res_t'{1'b1, 7'(stack_at[x] + 1), x == top});
								x++;
							end
							hit = 1'b1;
						end
					end
				end
			end
		end
		if (!hit)
			pending_cycle_words.push_back(NO_CYCLE);
	endfunction

	// Update the bench graph, or run the search, for one accepted word
	function automatic void apply_word(cmd_t c, logic [6:0] s, logic [6:0] d);
		case (c)
			CMD_ADD: begin
				if (s >= 1 && s <= GRAPH_NODES && d >= 1 && d <= GRAPH_NODES) begin
					edge_rows[s - 7'd1][d - 7'd1] = 1'b1;
					graph_words++;
				end
			end
			CMD_RUN: begin
				search_for_cycle();
				graph_words++;
			end
			CMD_CLEAR: begin
				foreach (edge_rows[i]) edge_rows[i] = '0;
				graph_words++;
			end
			default: ;
		endcase
	endfunction

	// Offer one input word after a random gap and hold it until taken
	task automatic issue_word(cmd_t c, logic [6:0] s, logic [6:0] d,
			bit typed = 1'b0, res_t typed_res = NO_CYCLE);
		int unsigned gap;
		gap = $urandom_range(0, feed_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, d, s};
		s_tuser <= c;
		do @(posedge clk); while (!s_tready);
		if (typed)
			pending_cycle_words.push_back(typed_res);
		else
			apply_word(c, s, d);
	endtask

	// Drain all results, let trailing edge writes settle, then write node_count
	task automatic write_node_count(logic [6:0] value);
		s_tvalid <= 1'b0;
		while (pending_cycle_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		node_count_q = value;
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result sink: check each word, stall at random, one long hold on request
	initial begin : result_sink
		int unsigned stall, gap_max, seen;
		res_t        want;
		stall = 0;
		gap_max = 19;
		seen = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_cycle_words.size() == 0) begin
					$error("result word with nothing expected: found %0b node %0d last %0b",
						m_tuser[0], m_tdata[6:0], m_tlast);
					error_count++;
				end else begin
					want = pending_cycle_words.pop_front();
					if (m_tuser[0] !== want.found) begin
						$error("found: expected %0b, got %0b", want.found, m_tuser[0]);
						error_count++;
					end
					if (m_tdata[6:0] !== want.node) begin
						$error("cycle_node: expected %0d, got %0d", want.node, m_tdata[6:0]);
						error_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, m_tlast);
						error_count++;
					end
				end
				seen++;
				if (seen % 32 == 0)
					gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
				stall = $urandom_range(0, gap_max);
				if (hold_armed) begin
					hold_armed = 1'b0;
					stall = LONG_HOLD;
				end
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: give up after a long stretch with no word moving anywhere
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("directed_cycle_finder_core_tb: errors");
		$finish;
	end

	// Stimulus
	initial begin : stimulus
		int unsigned pick, span, n_edges, phase;
		logic [6:0]  new_count;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_NOP;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (opening_words[i]) begin
			if (opening_words[i].set_cfg)
				write_node_count(opening_words[i].cfg);
			issue_word(opening_words[i].cmd, opening_words[i].src, opening_words[i].dst,
				opening_words[i].typed, opening_words[i].res);
		end

		// Random phases: set node count, load edges, run
		phase = 0;
		while (graph_words < TARGET_WORDS) begin
			feed_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
			if (phase == 3) begin
				// Ring through every node: longest cycle, deepest stack; hold
				// the output so the second run stalls the input
				write_node_count(7'd64);
				issue_word(CMD_CLEAR, 7'd0, 7'd0);
				for (int k = 1; k < GRAPH_NODES; k++)
					issue_word(CMD_ADD, 7'(k), 7'(k + 1));
				issue_word(CMD_ADD, 7'd64, 7'd1);
				hold_armed = 1'b1;
				issue_word(CMD_RUN, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
				issue_word(CMD_RUN, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					new_count = 7'd0;
				else if (pick == 1)
					new_count = 7'd64;
				else if (pick == 2)
					new_count = 7'($urandom_range(65, 127));
				else if (pick < 6)
					new_count = 7'($urandom_range(13, 63));
				else
					new_count = 7'($urandom_range(1, 12));
				write_node_count(new_count);
				span = (new_count == 0 || new_count > GRAPH_NODES) ? GRAPH_NODES : new_count;
				if ($urandom_range(0, 2) == 0)
					issue_word(CMD_CLEAR, 7'($urandom_range(0, 127)),
						7'($urandom_range(0, 127)));
				n_edges = $urandom_range(1, (span < 12) ? span + 3 : 16);
				for (int e = 0; e < n_edges; e++) begin
					pick = $urandom_range(0, 15);
					if (pick == 0) begin
						// noise: unused command or an edge off the node range
						if ($urandom_range(0, 1))
							issue_word(CMD_NOP, 7'($urandom_range(0, 127)),
								7'($urandom_range(0, 127)));
						else
							issue_word(CMD_ADD, 7'($urandom_range(65, 127)),
								7'($urandom_range(0, 127)));
					end else if (pick == 1 && span < GRAPH_NODES) begin
						issue_word(CMD_ADD, 7'($urandom_range(1, span)),
							7'($urandom_range(span + 1, GRAPH_NODES)));
					end else begin
						issue_word(CMD_ADD, 7'($urandom_range(1, span)),
							7'($urandom_range(1, span)));
					end
				end
				issue_word(CMD_RUN, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
				// sometimes grow the graph and search again without a clear
				if ($urandom_range(0, 2) == 0) begin
					n_edges = $urandom_range(1, 3);
					for (int e = 0; e < n_edges; e++)
						issue_word(CMD_ADD, 7'($urandom_range(1, span)),
							7'($urandom_range(1, span)));
					issue_word(CMD_RUN, 7'($urandom_range(0, 127)),
						7'($urandom_range(0, 127)));
				end
			end
			phase++;
		end

		// Drain and watch for stray words
		s_tvalid <= 1'b0;
		while (pending_cycle_words.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (error_count == 0)
			$display("directed_cycle_finder_core_tb: clean");
		else
			$display("directed_cycle_finder_core_tb: errors");
		$finish;
	end

endmodule
